// File: rtl/core/der_tlv_stream_parser_top_assert.svh
// Assertion macros used by the DER TLV parser core
`ifndef DER_TLV_STREAM_PARSER_TOP_ASSERT_SVH
`define DER_TLV_STREAM_PARSER_TOP_ASSERT_SVH

// Overlapping implication, sampled on clk, off while rst_n is low
`define DERTLV_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("dertlv assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define DERTLV_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dertlv assertion failed");

`endif

// File: rtl/core/dertlv_pkg.sv
// Types and constants of the DER TLV stream parser
package dertlv_pkg;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN1,
    PH_LENX,
    PH_OCT,
    PH_INT
  } phase_t;

  localparam logic [2:0] EV_HDR = 3'd0;
  localparam logic [2:0] EV_SEQ = 3'd1;
  localparam logic [2:0] EV_STR = 3'd2;
  localparam logic [2:0] EV_OCT = 3'd3;
  localparam logic [2:0] EV_INT = 3'd4;
  localparam logic [2:0] EV_ERR = 3'd5;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_TAG  = 3'd1;
  localparam logic [2:0] ERR_INT_LEN  = 3'd2;
  localparam logic [2:0] ERR_OVERRUN  = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW = 3'd5;
  localparam logic [2:0] ERR_INDEF    = 3'd6;

  localparam logic [7:0]  TAG_SEQ   = 8'h30;
  localparam logic [7:0]  TAG_OCT   = 8'h04;
  localparam logic [7:0]  TAG_INT   = 8'h02;
  localparam logic [7:0]  LEN_INDEF = 8'h80;
  localparam logic [31:0] INT_LEN   = 32'd4;
  localparam logic [6:0]  MAX_LENGTH_BYTES = 7'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] value;
    logic [31:0] elem_length;
    logic [3:0]  nest_depth;
    logic        last_of_string;
    logic [3:0]  seqs_closed;
    logic [2:0]  error_code;
  } res_t;

endpackage

// File: rtl/core/der_tlv_stream_parser_top.sv
// Top level of the DER TLV stream parser
//
// Input stream: one DER byte per beat in in_tdata, in_tuser high on the
// first byte of a frame (a tag); it clears the parser, its sequence stack,
// the byte position and any sticky error before that byte is decoded.
// Output stream: one result beat per input beat, in the same order: event
// kind in out_tuser, value, length, depth, closed count and error code in
// out_tdata, out_tlast high on the final content byte of an octet string.
// Throughput: one byte per cycle while results are taken, set by the
// single decode step from the input register to the result register,
// with all stack end compares done in parallel.
// Reset (rst_n low, synchronous) empties both stages and returns the
// parser to expecting a tag with an empty stack.
// When the receiver stalls, the result register holds its beat, the input
// register takes one more byte if it is empty, and then in_tready drops until
// the result is taken.
module der_tlv_stream_parser_top #(
  parameter int NEST_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [31:0] value, [63:32] elem_length,
                                  // [67:64] nest_depth, [71:68] seqs_closed,
                                  // [74:72] error_code, [79:75] zero
  output logic [2:0]  out_tuser,  // [2:0] event_res
  output logic        out_tlast   // last_of_string
);

  dertlv_pkg::item_t in_item;
  dertlv_pkg::item_t item;
  dertlv_pkg::res_t  res;
  dertlv_pkg::res_t  out_res;
  logic              item_valid;
  logic              res_ready;
  logic              fire;

  assign in_item.in_byte     = in_tdata;
  assign in_item.frame_start = in_tuser[0];
  assign fire                = item_valid && res_ready;

  dertlv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (fire),
    .item       (item)
  );

  dertlv_core #(
    .NEST_DEPTH (NEST_DEPTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  dertlv_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .load_ready (res_ready),
    .res        (res),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {5'd0, out_res.error_code, out_res.seqs_closed,
                      out_res.nest_depth, out_res.elem_length, out_res.value};
  assign out_tuser = out_res.event_res;
  assign out_tlast = out_res.last_of_string;

endmodule

// File: rtl/core/dertlv_in_stage.sv
// Input register stage of the DER TLV parser
module dertlv_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dertlv_pkg::item_t  in_item,
  output logic               item_valid,
  input  logic               item_take,
  output dertlv_pkg::item_t  item
);

  logic              valid_r;
  dertlv_pkg::item_t item_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// File: rtl/core/dertlv_core.sv
// Header decode, length tracking and sequence stack of the DER TLV parser
module dertlv_core #(
  parameter int NEST_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  dertlv_pkg::item_t item,
  output dertlv_pkg::res_t  res
);

  `include "der_tlv_stream_parser_top_assert.svh"

  localparam int SPW = $clog2(NEST_DEPTH + 1);
  localparam int IW  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  dertlv_pkg::phase_t phase_r, phase_nxt, phase_c;
  logic [7:0]  tag_r, tag_nxt, tag_c;
  logic [31:0] lacc_r, lacc_nxt, lacc_c;
  logic [2:0]  lbl_r, lbl_nxt, lbl_c;
  logic [31:0] cl_r, cl_nxt, cl_c;
  logic [31:0] ish_r, ish_nxt, ish_c;
  logic [31:0] pos_r, pos_nxt, pos_c;
  logic [SPW-1:0] sp_r, sp_nxt, sp_c;
  logic        err_r, err_nxt, err_c;
  logic [31:0] stk_r [NEST_DEPTH];

  logic [7:0]  b;
  logic [32:0] next_pos;
  logic [33:0] end_pos;
  logic [31:0] top_c;
  logic [31:0] len;
  logic [31:0] lacc_shift;
  logic [31:0] ish_shift;
  logic [31:0] cl_dec;
  logic [2:0]  lbl_dec;
  logic        hdr_done;
  logic        push;
  logic [SPW-1:0] sp_push;
  logic [SPW-1:0] closed;
  logic [NEST_DEPTH-1:0] match;
  logic [2:0]  err_code;
  logic [2:0]  ev;
  logic [31:0] val;
  logic [31:0] elen;
  logic        last;

  assign b        = item.in_byte;
  assign phase_c  = item.frame_start ? dertlv_pkg::PH_TAG : phase_r;
  assign tag_c    = item.frame_start ? 8'd0 : tag_r;
  assign lacc_c   = item.frame_start ? 32'd0 : lacc_r;
  assign lbl_c    = item.frame_start ? 3'd0 : lbl_r;
  assign cl_c     = item.frame_start ? 32'd0 : cl_r;
  assign ish_c    = item.frame_start ? 32'd0 : ish_r;
  assign pos_c    = item.frame_start ? 32'd0 : pos_r;
  assign sp_c     = item.frame_start ? '0 : sp_r;
  assign err_c    = item.frame_start ? 1'b0 : err_r;
  assign next_pos = {1'b0, pos_c} + 33'd1;
  assign top_c    = stk_r[IW'(sp_c - 1'b1)];
  assign pos_nxt  = (pos_c != 32'hFFFF_FFFF) ? pos_c + 32'd1 : pos_c;
  assign lacc_shift = {lacc_c[23:0], b};
  assign ish_shift  = {ish_c[23:0], b};
  assign cl_dec     = (cl_c != 32'd0) ? cl_c - 32'd1 : 32'd0;
  assign lbl_dec    = (lbl_c != 3'd0) ? lbl_c - 3'd1 : 3'd0;

  // next state
  always_comb begin
    phase_nxt = phase_c;
    tag_nxt   = tag_c;
    lacc_nxt  = lacc_c;
    lbl_nxt   = lbl_c;
    cl_nxt    = cl_c;
    ish_nxt   = ish_c;
    err_nxt   = err_c;
    sp_nxt    = sp_c;
    sp_push   = sp_c;
    push      = 1'b0;
    hdr_done  = 1'b0;
    len       = 32'd0;
    end_pos   = '0;
    err_code  = dertlv_pkg::ERR_NONE;
    ev        = dertlv_pkg::EV_HDR;
    val       = 32'd0;
    elen      = 32'd0;
    last      = 1'b0;
    closed    = '0;
    match     = '0;
    if (err_c) begin
      ev       = dertlv_pkg::EV_ERR;
      err_code = tag_c[2:0];
    end else begin
      unique case (phase_c)
        dertlv_pkg::PH_TAG: begin
          if (b == dertlv_pkg::TAG_SEQ || b == dertlv_pkg::TAG_OCT ||
              b == dertlv_pkg::TAG_INT) begin
            tag_nxt   = b;
            phase_nxt = dertlv_pkg::PH_LEN1;
          end else begin
            err_code = dertlv_pkg::ERR_BAD_TAG;
          end
        end
        dertlv_pkg::PH_LEN1: begin
          priority if (!b[7]) begin
            len      = {24'd0, b};
            hdr_done = 1'b1;
          end else if (b == dertlv_pkg::LEN_INDEF) begin
            err_code = dertlv_pkg::ERR_INDEF;
          end else if (b[6:0] > dertlv_pkg::MAX_LENGTH_BYTES) begin
            err_code = dertlv_pkg::ERR_TOO_LONG;
          end else begin
            lbl_nxt   = b[2:0];
            lacc_nxt  = 32'd0;
            phase_nxt = dertlv_pkg::PH_LENX;
          end
        end
        dertlv_pkg::PH_LENX: begin
          lacc_nxt = lacc_shift;
          lbl_nxt  = lbl_dec;
          if (lbl_dec == 3'd0) begin
            len      = lacc_shift;
            hdr_done = 1'b1;
          end
        end
        dertlv_pkg::PH_OCT: begin
          ev     = dertlv_pkg::EV_OCT;
          val    = {24'd0, b};
          cl_nxt = cl_dec;
          if (cl_dec == 32'd0) begin
            last      = 1'b1;
            phase_nxt = dertlv_pkg::PH_TAG;
          end
        end
        dertlv_pkg::PH_INT: begin
          ish_nxt = ish_shift;
          cl_nxt  = cl_dec;
          if (cl_dec == 32'd0) begin
            ev        = dertlv_pkg::EV_INT;
            val       = ish_shift;
            phase_nxt = dertlv_pkg::PH_TAG;
          end
        end
        default: begin
          phase_nxt = dertlv_pkg::PH_TAG;
        end
      endcase

      if (hdr_done) begin
        end_pos = {1'b0, next_pos} + {2'b00, len};
        priority if (tag_c == dertlv_pkg::TAG_INT && len != dertlv_pkg::INT_LEN) begin
          err_code = dertlv_pkg::ERR_INT_LEN;
        end else if (end_pos[33:32] != 2'b00) begin
          err_code = dertlv_pkg::ERR_TOO_LONG;
        end else if (sp_c != '0 && end_pos[31:0] > top_c) begin
          err_code = dertlv_pkg::ERR_OVERRUN;
        end else if (tag_c == dertlv_pkg::TAG_SEQ) begin
          if (sp_c >= SPW'(NEST_DEPTH)) begin
            err_code = dertlv_pkg::ERR_OVERFLOW;
          end else begin
            push      = 1'b1;
            ev        = dertlv_pkg::EV_SEQ;
            elen      = len;
            phase_nxt = dertlv_pkg::PH_TAG;
          end
        end else if (tag_c == dertlv_pkg::TAG_OCT) begin
          ev        = dertlv_pkg::EV_STR;
          elen      = len;
          cl_nxt    = len;
          phase_nxt = (len == 32'd0) ? dertlv_pkg::PH_TAG : dertlv_pkg::PH_OCT;
        end else begin
          cl_nxt    = dertlv_pkg::INT_LEN;
          ish_nxt   = 32'd0;
          phase_nxt = dertlv_pkg::PH_INT;
        end
      end

      sp_push = sp_c + SPW'(push);
      for (int i = 0; i < NEST_DEPTH; i++) begin
        match[i] = (SPW'(i) < sp_push) &&
                   ({1'b0, ((push && SPW'(i) == sp_c) ? end_pos[31:0] : stk_r[i])}
                    == next_pos);
      end

      // ends on the stack are ordered, so matches run down from the top
      if (err_code == dertlv_pkg::ERR_NONE && phase_nxt != dertlv_pkg::PH_TAG &&
          (|match)) begin
        err_code = dertlv_pkg::ERR_OVERRUN;
      end

      if (err_code == dertlv_pkg::ERR_NONE && phase_nxt == dertlv_pkg::PH_TAG) begin
        closed = SPW'($countones(match));
      end
      sp_nxt = sp_push - closed;

      if (err_code != dertlv_pkg::ERR_NONE) begin
        err_nxt   = 1'b1;
        tag_nxt   = {5'd0, err_code};
        phase_nxt = dertlv_pkg::PH_TAG;
        push      = 1'b0;
        sp_nxt    = sp_c;
      end
    end
  end

  // result
  always_comb begin
    res.event_res      = (err_code != dertlv_pkg::ERR_NONE) ? dertlv_pkg::EV_ERR : ev;
    res.value          = (err_code != dertlv_pkg::ERR_NONE) ? 32'd0 : val;
    res.elem_length    = (err_code != dertlv_pkg::ERR_NONE) ? 32'd0 : elen;
    res.nest_depth     = 4'(sp_c);
    res.last_of_string = (err_code != dertlv_pkg::ERR_NONE) ? 1'b0 : last;
    res.seqs_closed    = (err_code != dertlv_pkg::ERR_NONE) ? 4'd0 : 4'(closed);
    res.error_code     = err_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dertlv_pkg::PH_TAG;
      tag_r   <= 8'd0;
      lacc_r  <= 32'd0;
      lbl_r   <= 3'd0;
      cl_r    <= 32'd0;
      ish_r   <= 32'd0;
      pos_r   <= 32'd0;
      sp_r    <= '0;
      err_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      lacc_r  <= lacc_nxt;
      lbl_r   <= lbl_nxt;
      cl_r    <= cl_nxt;
      ish_r   <= ish_nxt;
      pos_r   <= pos_nxt;
      sp_r    <= sp_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && push) begin
      stk_r[sp_c[IW-1:0]] <= end_pos[31:0];
    end
  end

  `DERTLV_ASSERT_IMP(a_sp_bound, 1'b1, sp_r <= SPW'(NEST_DEPTH))
  `DERTLV_ASSERT_NXT(a_sticky_hold, fire && err_r && !item.frame_start, err_r)
  `DERTLV_ASSERT_IMP(a_oct_event, fire && !err_c && phase_c == dertlv_pkg::PH_OCT, res.event_res == dertlv_pkg::EV_OCT || res.event_res == dertlv_pkg::EV_ERR)

endmodule

// File: rtl/core/dertlv_out_stage.sv
// Result register of the DER TLV parser
module dertlv_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  output logic             load_ready,
  input  dertlv_pkg::res_t res,
  output logic             out_valid,
  input  logic             out_ready,
  output dertlv_pkg::res_t out_res
);

  logic             valid_r;
  dertlv_pkg::res_t res_r;

  assign load_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
